>>> sv/stick_radial_dead_zone_defines.svh
// Assertion macros for the stick radial dead-zone block.
`ifndef STICK_RADIAL_DEAD_ZONE_DEFINES_SVH
`define STICK_RADIAL_DEAD_ZONE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define SRDZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("srdz check failed");

// Next-cycle implication, disabled while reset is asserted
`define SRDZ_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("srdz check failed");

// Next-cycle implication that also holds across reset
`define SRDZ_ASSERT_ALW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("srdz check failed");

`endif

>>> sv/srdz_pkg.sv
// Shared constants and types for the stick radial dead-zone pipeline.
package srdz_pkg;

    localparam int NSQ    = 17;          // square root stages, one root bit each
    localparam int NDV    = 17;          // divider stages, one quotient bit each
    localparam int ST_MAG = 0;
    localparam int ST_SQR = 1;
    localparam int ST_SUM = 2;
    localparam int ST_SQ0 = 3;
    localparam int ST_PRD = ST_SQ0 + NSQ;
    localparam int ST_DV0 = ST_PRD + 1;
    localparam int ST_OUT = ST_DV0 + NDV;
    localparam int NS     = ST_OUT + 1;

    localparam int MAG_W = 17;           // Q16 magnitude, at most 65536
    localparam int SUM_W = 34;
    localparam int ROOT_W = 17;
    localparam int REM_W = 19;
    localparam int DEN_W = 34;
    localparam int NUM_W = 49;
    localparam int QUO_W = 17;
    localparam int OUT_W = 17;

    localparam logic [14:0] DZ_RESET = 15'd7849;
    localparam logic [14:0] DZ_MAX   = 15'd32766;

    // sideband that rides along the square root stages
    typedef struct packed {
        logic [MAG_W-1:0] mx;
        logic [MAG_W-1:0] my;
        logic             nx;
        logic             ny;
        logic [MAG_W-1:0] z;
    } t_side;

    // sideband that rides along the divider stages
    typedef struct packed {
        logic nx;
        logic ny;
        logic zero;
    } t_dside;

endpackage

>>> sv/srdz_sqrt.sv
// Pipelined integer square root, one root bit per stage.
module srdz_sqrt (
    input  logic                            i_clk,
    input  logic [srdz_pkg::NSQ-1:0]        i_en,
    input  logic [srdz_pkg::SUM_W-1:0]      i_s,
    output logic [srdz_pkg::ROOT_W-1:0]     o_root
);

    logic [srdz_pkg::REM_W-1:0]  r_rem  [srdz_pkg::NSQ];
    logic [srdz_pkg::ROOT_W-1:0] r_root [srdz_pkg::NSQ];
    logic [srdz_pkg::SUM_W-1:0]  r_s    [srdz_pkg::NSQ];
    logic [srdz_pkg::REM_W-1:0]  n_rem  [srdz_pkg::NSQ];
    logic [srdz_pkg::ROOT_W-1:0] n_root [srdz_pkg::NSQ];
    logic [srdz_pkg::SUM_W-1:0]  n_s    [srdz_pkg::NSQ];

    // one digit step per stage: bring down two bits, try root*4+1
    always_comb begin
        logic [srdz_pkg::REM_W-1:0]  p_rem;
        logic [srdz_pkg::ROOT_W-1:0] p_root;
        logic [srdz_pkg::SUM_W-1:0]  p_s;
        logic [srdz_pkg::REM_W+1:0]  cur;
        logic [srdz_pkg::REM_W+1:0]  trial;
        for (int k = 0; k < srdz_pkg::NSQ; k++) begin
            if (k == 0) begin
                p_rem  = '0;
                p_root = '0;
                p_s    = i_s;
            end else begin
                p_rem  = r_rem[k-1];
                p_root = r_root[k-1];
                p_s    = r_s[k-1];
            end
            cur   = {p_rem, p_s[srdz_pkg::SUM_W-1 -: 2]};
            trial = {2'b00, p_root, 2'b01};
            if (cur >= trial) begin
                n_rem[k]  = srdz_pkg::REM_W'(cur - trial);
                n_root[k] = {p_root[srdz_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = cur[srdz_pkg::REM_W-1:0];
                n_root[k] = {p_root[srdz_pkg::ROOT_W-2:0], 1'b0};
            end
            n_s[k] = {p_s[srdz_pkg::SUM_W-3:0], 2'b00};
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < srdz_pkg::NSQ; k++) begin
            if (i_en[k]) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_s[k]    <= n_s[k];
            end
        end
    end

    assign o_root = r_root[srdz_pkg::NSQ-1];

endmodule

>>> sv/srdz_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module srdz_div (
    input  logic                            i_clk,
    input  logic [srdz_pkg::NDV-1:0]        i_en,
    input  logic [srdz_pkg::NUM_W-1:0]      i_num,
    input  logic [srdz_pkg::DEN_W-1:0]      i_den,
    output logic [srdz_pkg::QUO_W-1:0]      o_quo
);

    localparam int CMP_W = srdz_pkg::DEN_W + srdz_pkg::NDV;

    logic [srdz_pkg::NUM_W-1:0] r_rem [srdz_pkg::NDV];
    logic [srdz_pkg::DEN_W-1:0] r_den [srdz_pkg::NDV];
    logic [srdz_pkg::QUO_W-1:0] r_q   [srdz_pkg::NDV];
    logic [srdz_pkg::NUM_W-1:0] n_rem [srdz_pkg::NDV];
    logic [srdz_pkg::QUO_W-1:0] n_q   [srdz_pkg::NDV];

    // stage k decides quotient bit NDV-1-k
    always_comb begin
        logic [srdz_pkg::NUM_W-1:0] p_rem;
        logic [srdz_pkg::DEN_W-1:0] p_den;
        logic [srdz_pkg::QUO_W-1:0] p_q;
        logic [CMP_W-1:0]           sh;
        logic [CMP_W-1:0]           rx;
        for (int k = 0; k < srdz_pkg::NDV; k++) begin
            if (k == 0) begin
                p_rem = i_num;
                p_den = i_den;
                p_q   = '0;
            end else begin
                p_rem = r_rem[k-1];
                p_den = r_den[k-1];
                p_q   = r_q[k-1];
            end
            sh = CMP_W'(p_den) << (srdz_pkg::NDV - 1 - k);
            rx = CMP_W'(p_rem);
            if (rx >= sh) begin
                n_rem[k] = srdz_pkg::NUM_W'(rx - sh);
                n_q[k]   = p_q | (srdz_pkg::QUO_W'(1) << (srdz_pkg::NDV - 1 - k));
            end else begin
                n_rem[k] = p_rem;
                n_q[k]   = p_q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < srdz_pkg::NDV; k++) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= (k == 0) ? i_den : r_den[k-1];
                r_q[k]   <= n_q[k];
            end
        end
    end

    assign o_quo = r_q[srdz_pkg::NDV-1];

endmodule

>>> sv/stick_radial_dead_zone.sv
// Top level of the stick radial dead-zone pipeline.
// Each sample goes through a 39-stage pipeline and one result leaves per cycle at full rate.
// The depth is set by the square root (one root bit per stage, 17 stages) and the two axis
// dividers (one quotient bit per stage, 17 stages), plus stages for normalization, squaring,
// summing, scaling products and output saturation. Every stage holds independently on
// backpressure, so empty slots close up behind a stalled output.
// The dead-zone register may be written at any time the pipeline holds no sample.
module stick_radial_dead_zone (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [14:0] i_cfg_data,      // dead_zone
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [15:0] axis_x, [31:16] axis_y
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata     // [16:0] out_x, [33:17] out_y, [39:34] zero
);

    localparam int NS = srdz_pkg::NS;

    logic [14:0]    r_dead_zone;
    logic [NS-1:0]  r_v;
    logic [NS-1:0]  w_en;

    // configuration register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dead_zone <= srdz_pkg::DZ_RESET;
        end else if (i_cfg_valid) begin
            r_dead_zone <= i_cfg_data;
        end
    end

    // per-stage load enables: a stage moves when it is empty or its successor moves
    always_comb begin
        w_en[NS-1] = !r_v[NS-1] || m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign s_axis_tready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // Q16 magnitude of one raw axis: 2*|a| below zero, a*65536/32767 above
    function automatic logic [16:0] axis_mag(input logic [15:0] a);
        logic [16:0] m;
        logic [16:0] t;
        begin
            if (a[15]) begin
                m = 17'd65536 - {1'b0, a};
                axis_mag = {m[15:0], 1'b0};
            end else begin
                t = {a, 1'b0};
                if (t >= 17'd65534) begin
                    axis_mag = t + 17'd2;
                end else if (t >= 17'd32767) begin
                    axis_mag = t + 17'd1;
                end else begin
                    axis_mag = t;
                end
            end
        end
    endfunction

    // stage 0: normalize axes and dead zone
    srdz_pkg::t_side r_side0;
    logic [14:0]     w_d;
    logic [16:0]     w_d2;
    assign w_d  = (r_dead_zone > srdz_pkg::DZ_MAX) ? srdz_pkg::DZ_MAX : r_dead_zone;
    assign w_d2 = {1'b0, w_d, 1'b0};

    always_ff @(posedge i_clk) begin
        if (w_en[srdz_pkg::ST_MAG]) begin
            r_side0.mx <= axis_mag(s_axis_tdata[15:0]);
            r_side0.my <= axis_mag(s_axis_tdata[31:16]);
            r_side0.nx <= s_axis_tdata[15];
            r_side0.ny <= s_axis_tdata[31];
            r_side0.z  <= (w_d2 >= 17'd32767) ? w_d2 + 17'd1 : w_d2;
        end
    end

    // stage 1: squares
    srdz_pkg::t_side           r_side1;
    logic [srdz_pkg::SUM_W-1:0] r_sqx;
    logic [srdz_pkg::SUM_W-1:0] r_sqy;
    always_ff @(posedge i_clk) begin
        if (w_en[srdz_pkg::ST_SQR]) begin
            r_side1 <= r_side0;
            r_sqx   <= r_side0.mx * r_side0.mx;
            r_sqy   <= r_side0.my * r_side0.my;
        end
    end

    // stage 2: squared length
    srdz_pkg::t_side           r_side2;
    logic [srdz_pkg::SUM_W-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (w_en[srdz_pkg::ST_SUM]) begin
            r_side2 <= r_side1;
            r_sum   <= r_sqx + r_sqy;
        end
    end

    // square root stages with sideband alongside
    logic [srdz_pkg::ROOT_W-1:0] w_root;
    srdz_pkg::t_side             r_sqs [srdz_pkg::NSQ];

    srdz_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en[srdz_pkg::ST_PRD-1:srdz_pkg::ST_SQ0]),
        .i_s    (r_sum),
        .o_root (w_root)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < srdz_pkg::NSQ; k++) begin
            if (w_en[srdz_pkg::ST_SQ0 + k]) begin
                r_sqs[k] <= (k == 0) ? r_side2 : r_sqs[k-1];
            end
        end
    end

    // scaling products: mag*(R-z)*32768 over R*(65536-z)
    srdz_pkg::t_side             w_ps;
    logic [16:0]                 w_rz;
    logic [16:0]                 w_fz;
    logic [srdz_pkg::NUM_W-1:0]  r_num_x;
    logic [srdz_pkg::NUM_W-1:0]  r_num_y;
    logic [srdz_pkg::DEN_W-1:0]  r_den;
    srdz_pkg::t_dside            r_pds;
    logic [33:0]                 w_px;
    logic [33:0]                 w_py;

    assign w_ps = r_sqs[srdz_pkg::NSQ-1];
    assign w_rz = w_root - w_ps.z;
    assign w_fz = 17'd65536 - w_ps.z;
    assign w_px = w_ps.mx * w_rz;
    assign w_py = w_ps.my * w_rz;

    always_ff @(posedge i_clk) begin
        if (w_en[srdz_pkg::ST_PRD]) begin
            r_num_x    <= {w_px, 15'd0};
            r_num_y    <= {w_py, 15'd0};
            r_den      <= w_root * w_fz;
            r_pds.nx   <= w_ps.nx;
            r_pds.ny   <= w_ps.ny;
            r_pds.zero <= (w_root < w_ps.z) || (w_root == '0);
        end
    end

    // per-axis dividers with sideband alongside
    logic [srdz_pkg::QUO_W-1:0] w_qx;
    logic [srdz_pkg::QUO_W-1:0] w_qy;
    srdz_pkg::t_dside           r_dvs [srdz_pkg::NDV];

    srdz_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en[srdz_pkg::ST_OUT-1:srdz_pkg::ST_DV0]),
        .i_num (r_num_x),
        .i_den (r_den),
        .o_quo (w_qx)
    );

    srdz_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en[srdz_pkg::ST_OUT-1:srdz_pkg::ST_DV0]),
        .i_num (r_num_y),
        .i_den (r_den),
        .o_quo (w_qy)
    );

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < srdz_pkg::NDV; k++) begin
            if (w_en[srdz_pkg::ST_DV0 + k]) begin
                r_dvs[k] <= (k == 0) ? r_pds : r_dvs[k-1];
            end
        end
    end

    // saturate and apply the axis sign
    function automatic logic [16:0] sign_sat(input logic [16:0] q, input logic neg);
        begin
            if (neg) begin
                sign_sat = (q > 17'd65536) ? 17'h10000 : 17'(17'd0 - q);
            end else begin
                sign_sat = (q > 17'd65535) ? 17'd65535 : q;
            end
        end
    endfunction

    srdz_pkg::t_dside w_ds;
    logic [16:0]      r_out_x;
    logic [16:0]      r_out_y;
    assign w_ds = r_dvs[srdz_pkg::NDV-1];

    always_ff @(posedge i_clk) begin
        if (w_en[srdz_pkg::ST_OUT]) begin
            r_out_x <= w_ds.zero ? 17'd0 : sign_sat(w_qx, w_ds.nx);
            r_out_y <= w_ds.zero ? 17'd0 : sign_sat(w_qy, w_ds.ny);
        end
    end

    assign m_axis_tvalid = r_v[NS-1];
    assign m_axis_tdata  = {6'd0, r_out_y, r_out_x};

endmodule

>>> sv/srdz_checker.sv
// Port-level checks for the stick radial dead-zone block, bound to the top level.
`include "stick_radial_dead_zone_defines.svh"

module srdz_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_cfg_ready,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [39:0] m_axis_tdata
);

    // a stalled result stays and holds its data
    `SRDZ_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // with no result waiting, the pipeline always takes a sample
    `SRDZ_ASSERT_IMP(a_in_free, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // reset empties the pipeline
    `SRDZ_ASSERT_ALW(a_rst_empty, i_clk, !i_rst_n, !m_axis_tvalid)

    // padding bits stay zero and the register port never blocks
    `SRDZ_ASSERT_IMP(a_pad_cfg, i_clk, i_rst_n, m_axis_tvalid, (m_axis_tdata[39:34] == 6'd0) && o_cfg_ready)

endmodule

bind stick_radial_dead_zone srdz_checker u_srdz_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_cfg_ready   (o_cfg_ready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> tb/sv/tb_stick_radial_dead_zone.sv
// Testbench for the stick radial dead-zone pipeline: directed table, then random samples.
`timescale 1ns / 1ps

module tb_stick_radial_dead_zone;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 60;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [14:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    stick_radial_dead_zone uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state: a copy of the dead-zone register
    logic [14:0] dz_reg = srdz_pkg::DZ_RESET;
    logic [39:0] expected_q[$];
    int          errors = 0;
    int          send_idle = 0;   // percent
    int          recv_idle = 0;
    bit          hold_recv = 1'b0;
    int          quiet = 0;

    // Q16 magnitude of one raw axis
    function automatic logic [16:0] norm_axis(input logic [15:0] a);
        if (a[15])
            return 17'(2 * (32'd65536 - {16'd0, a}));
        return 17'(({48'd0, a} * 64'd65536) / 64'd32767);
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic logic [16:0] scale_one(input logic [16:0] m, input bit neg,
                                              input logic [63:0] len, input logic [63:0] z);
        logic [63:0] q;
        q = ({47'd0, m} * (len - z) * 64'd32768) / (len * (64'd65536 - z));
        if (neg) begin
            if (q > 65536) q = 65536;
            return 17'(64'd0 - q);
        end
        if (q > 65535) q = 65535;
        return 17'(q);
    endfunction

    // Conditioned stick output for one sample under the current register
    function automatic logic [39:0] dead_zone_result(input logic [31:0] sample);
        logic [16:0] mx, my;
        logic [63:0] z, len;
        logic [14:0] d;
        mx = norm_axis(sample[15:0]);
        my = norm_axis(sample[31:16]);
        d = (dz_reg > srdz_pkg::DZ_MAX) ? srdz_pkg::DZ_MAX : dz_reg;
        z = ({49'd0, d} * 64'd65536) / 64'd32767;
        len = int_sqrt({47'd0, mx} * mx + {47'd0, my} * my);
        if (len < z || len == 0) return '0;
        return {6'd0, scale_one(my, sample[31], len, z), scale_one(mx, sample[15], len, z)};
    endfunction

    task automatic report_mismatch(input string what, input logic [39:0] got,
                                   input logic [39:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    // Result checking, receiver idling and watchdog
    always @(posedge i_clk) begin
        logic [39:0] w;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, '0);
                end else begin
                    w = expected_q.pop_front();
                    if (m_axis_tdata[16:0] != w[16:0])
                        report_mismatch("out_x", m_axis_tdata, w);
                    if (m_axis_tdata[33:17] != w[33:17])
                        report_mismatch("out_y", m_axis_tdata, w);
                    if (m_axis_tdata[39:34] != w[39:34])
                        report_mismatch("pad", m_axis_tdata, w);
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("FAIL stick_radial_dead_zone");
                $finish;
            end
        end
        m_axis_tready <= !hold_recv && ($urandom_range(99) >= recv_idle);
    end

    // Long receiver hold-off counted in its own process
    task automatic hold_receiver(input int cycles);
        hold_recv = 1'b1;
        repeat (cycles) @(posedge i_clk);
        hold_recv = 1'b0;
    endtask

    // valid stays up between back-to-back transfers; idle gaps and drain drop it
    task automatic send_sample(input logic [31:0] sample);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sample;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_q.push_back(dead_zone_result(sample));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_dead_zone(input logic [14:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        dz_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(2000)) - 1000);
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed rows: sample, known result, whether the result is typed in
    typedef struct {
        logic [31:0] sample;
        logic [39:0] result;
        bit          known;
    } t_row;

    t_row rows[$];
    logic [14:0] dz_set[6] = '{15'd0, 15'd32766, 15'd32767, 15'd1, 15'd16384, 15'h5555};

    initial begin
        // Directed table under the reset dead zone
        rows.push_back('{32'h0000_0000, 40'd0, 1'b1});   // centered stick
        rows.push_back('{32'h0010_FFF0, 40'd0, 1'b1});   // inside dead zone
        rows.push_back('{32'h0000_7FFF, 40'd0, 1'b0});
        rows.push_back('{32'h0000_8000, 40'd0, 1'b0});
        rows.push_back('{32'h7FFF_0000, 40'd0, 1'b0});
        rows.push_back('{32'h8000_0000, 40'd0, 1'b0});
        rows.push_back('{32'h7FFF_7FFF, 40'd0, 1'b0});
        rows.push_back('{32'h8000_8000, 40'd0, 1'b0});
        rows.push_back('{32'h8000_7FFF, 40'd0, 1'b0});
        rows.push_back('{32'h7FFF_8000, 40'd0, 1'b0});
        rows.push_back('{32'h1000_F000, 40'd0, 1'b0});
        rows.push_back('{32'h2000_2000, 40'd0, 1'b0});
        rows.push_back('{32'hFFFF_0001, 40'd0, 1'b1});   // tiny, inside dead zone

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            send_sample(rows[k].sample);
            if (rows[k].known) expected_q[$] = rows[k].result;
        end
        drain();

        // Zero dead zone, zero stick and the full extremes
        write_dead_zone(15'd0);
        send_sample(32'h0000_0000);
        expected_q[$] = 40'd0;
        send_sample(32'h8000_8000);
        send_sample(32'h7FFF_0000);
        drain();

        // Random phases over several register settings and idling mixes
        for (int ph = 0; ph < 9; ph++) begin
            case (ph / 3)
                0: begin send_idle = 11; recv_idle = 77; end
                1: begin send_idle = 77; recv_idle = 11; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase
            write_dead_zone(ph < 6 ? dz_set[ph] : 15'($urandom));
            if (ph == 6) begin
                fork hold_receiver(300); join_none
            end
            repeat (190) send_sample({rand_axis(), rand_axis()});
            drain();   // sender pauses until all results are back
        end

        send_idle = 0;
        write_dead_zone(srdz_pkg::DZ_RESET);
        repeat (30) send_sample({16'($urandom), 16'($urandom)});
        drain();

        if (errors == 0)
            $display("PASS stick_radial_dead_zone");
        else
            $display("FAIL stick_radial_dead_zone");
        $finish;
    end

endmodule
